[rtl/kthl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kthl_pkg
// shared types and fixed widths of the k-th largest selection block
// ----------------------------------------------------------------------------
package kthl_pkg;

  localparam int VALUE_W = 32;  // data value width, two's complement
  localparam int RANK_W  = 5;   // rank register width

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [RANK_W-1:0]  rank_t;

endpackage

[rtl/kthl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kthl_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module kthl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/kth_largest_min_buffer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_largest_min_buffer_unit
// streaming k-th largest value of each data set, kept in a buffer of the k
// largest values with a tracked minimum
// ----------------------------------------------------------------------------
// Values arrive one per transfer on the slave stream, tlast marking the final
// value of a set. The block keeps the k largest values of the set in a buffer
// RAM of MAX_RANK entries plus the slot and value of the buffer minimum. On the
// final value it sends one transfer on the master stream: the buffer minimum,
// which is the k-th largest value, with tuser set (and data zero) when the set
// held fewer than k values; it then starts over for the next set. An item
// that leaves the buffer untouched goes straight to the finish step; an item
// that fills a slot or replaces the minimum is followed by a rescan of the
// buffer RAM for the new minimum, over the filled slots while filling or
// over k slots on a replacement, one entry read and compared per cycle through
// the single read port. On a final value the block also waits until an earlier
// result has been taken. No input is taken while an item is in progress.
// rank_k is written through the cfg channel, always ready; the user must
// write it only while idle, which the block itself does not enforce; 0 acts
// as 1 and values above MAX_RANK act as MAX_RANK. Buffer entries are never
// read before they are written, so the RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module kth_largest_min_buffer_unit #(
  parameter int MAX_RANK = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] value
  input  logic        s_tlast,    // is_last
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] kth_value
  output logic        m_tuser,    // [0] too_few
  // rank register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // [4:0] rank_k
);

  // count width holds 0..MAX_RANK, slot width addresses the buffer
  localparam int CW = $clog2(MAX_RANK + 1);
  localparam int SW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  kthl_pkg::rank_t  rank_k;
  logic [CW-1:0]    fill_count;
  logic [SW-1:0]    min_slot;
  kthl_pkg::value_t min_val;     // value of the buffer entry at min_slot, set by each rescan
  logic             is_last;
  logic [CW-1:0]    scan_count;
  logic [CW-1:0]    issue_cnt;
  logic             rd_valid;
  logic             rd_first;
  logic             rd_last;
  logic [SW-1:0]    rd_slot;
  logic             out_valid;
  kthl_pkg::value_t out_value;
  logic             out_too_few;

  logic [CW-1:0]    k_eff;
  logic             accept;
  logic             fill_case;
  logic             replace;
  logic             issuing;
  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  logic [31:0]      ram_rdata;
  kthl_pkg::value_t rd_value;
  logic             too_few_now;
  logic             load_result;

  // effective rank, clamped to 1..MAX_RANK
  always_comb begin
    if (rank_k == '0) begin
      k_eff = CW'(1);
    end else if (32'(rank_k) > MAX_RANK) begin
      k_eff = CW'(MAX_RANK);
    end else begin
      k_eff = CW'(rank_k);
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // decisions made in the transfer cycle
  assign fill_case = (fill_count < k_eff);
  assign replace   = (kthl_pkg::value_t'(s_tdata) > min_val);

  // buffer write happens in the transfer cycle, before the rescan reads
  assign ram_we    = accept && (fill_case || replace);
  assign ram_waddr = fill_case ? fill_count[SW-1:0] : min_slot;

  // rescan read issue, one entry per cycle
  assign issuing = (state == ST_SCAN) && (issue_cnt < scan_count);
  assign rd_value = kthl_pkg::value_t'(ram_rdata);

  assign too_few_now = (fill_count < k_eff);

  // result register loads once the previous result is gone or leaving
  assign load_result = (state == ST_FINISH) && is_last && (!out_valid || m_tready);

  kthl_ram #(
    .WIDTH (kthl_pkg::VALUE_W),
    .DEPTH (MAX_RANK)
  ) u_buffer (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .re    (issuing),
    .raddr (issue_cnt[SW-1:0]),
    .rdata (ram_rdata)
  );

  // rank register
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= kthl_pkg::rank_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      rank_k <= cfg_data;
    end
  end

  // sequencer and buffer bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      min_slot   <= '0;
      is_last    <= 1'b0;
      scan_count <= '0;
      issue_cnt  <= '0;
      rd_valid   <= 1'b0;
      rd_first   <= 1'b0;
      rd_last    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      // read pipeline tags, data lands in the cycle after issue
      rd_valid <= issuing;
      rd_first <= issuing && (issue_cnt == '0);
      rd_last  <= issuing && (issue_cnt == scan_count - CW'(1));
      rd_slot  <= issue_cnt[SW-1:0];
      if (issuing) begin
        issue_cnt <= issue_cnt + CW'(1);
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            is_last   <= s_tlast;
            issue_cnt <= '0;
            if (fill_case) begin
              fill_count <= fill_count + CW'(1);
              scan_count <= fill_count + CW'(1);
              state      <= ST_SCAN;
            end else if (replace) begin
              scan_count <= k_eff;
              state      <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          // first slot wins on ties: update only on strictly smaller
          if (rd_valid && (rd_first || (rd_value < min_val))) begin
            min_val  <= rd_value;
            min_slot <= rd_slot;
          end
          if (rd_valid && rd_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!is_last) begin
            state <= ST_IDLE;
          end else if (load_result) begin
            out_too_few <= too_few_now;
            out_value   <= too_few_now ? '0 : min_val;
            fill_count  <= '0;
            min_slot    <= '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_too_few;

  // fill count never runs past the buffer depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_RANK))
    else $error("fill_count exceeds buffer depth");

  // tracked minimum slot always points inside the buffer
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    32'(min_slot) < MAX_RANK)
    else $error("min_slot outside buffer");

  // rescan never issues more reads than its count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt <= scan_count))
    else $error("rescan issued too many reads");

  // a new result is only loaded from the finish step of a final value
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid && !m_tready) && !$past(rst)) |->
      ($past(state) == ST_FINISH && $past(is_last)))
    else $error("result raised outside finish of a final value");

endmodule

[sim/kth_largest_min_buffer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_largest_min_buffer_checker
// watches the streams of the k-th largest unit and checks every result
// ----------------------------------------------------------------------------
// Follows each rank write and each input transfer with its own copy of the
// top-value buffer, works out the k-th largest value of every finished set
// and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module kth_largest_min_buffer_checker #(
  parameter int MAX_RANK = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] value
  input  logic        s_tlast,    // is_last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,    // [31:0] kth_value
  input  logic        m_tuser,    // [0] too_few
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,   // [4:0] rank_k
  output int          fail_count,
  output int          open_results
);

  typedef struct packed {
    kthl_pkg::value_t kth_value;
    logic             too_few;
  } kth_result_t;

  kthl_pkg::rank_t  rank_reg;
  kthl_pkg::value_t top_vals [MAX_RANK];
  int unsigned      min_idx;
  int unsigned      fill_cnt;
  kth_result_t      pending_kth [$];

  // slot of the smallest of the first count entries, lowest slot on ties
  function automatic int unsigned lowest_slot(int unsigned count);
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < count && i < MAX_RANK; i++) begin
      if (top_vals[i] < top_vals[best]) best = i;
    end
    return best;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : predict
    int unsigned      k;
    kthl_pkg::value_t v;
    kth_result_t      want;
    if (rst) begin
      rank_reg = 1;
      min_idx  = 0;
      fill_cnt = 0;
      pending_kth.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) rank_reg = cfg_data;

      // results first: a result never belongs to an input taken at the same edge
      if (m_tvalid && m_tready) begin
        if (pending_kth.size() == 0) begin
          note_failure($sformatf("unexpected result kth_value=%0d too_few=%0b",
                                 $signed(m_tdata), m_tuser));
        end else begin
          want = pending_kth.pop_front();
          if (m_tdata !== want.kth_value || m_tuser !== want.too_few)
            note_failure($sformatf(
              "result mismatch: expected kth_value=%0d too_few=%0b, got %0d %0b",
              want.kth_value, want.too_few, $signed(m_tdata), m_tuser));
        end
      end

      if (s_tvalid && s_tready) begin
        // rank 0 behaves as 1, anything above the buffer depth as the depth
        k = (rank_reg == 0) ? 1 : ((rank_reg > MAX_RANK) ? MAX_RANK : rank_reg);
        v = s_tdata;
        if (fill_cnt < k) begin
          top_vals[fill_cnt] = v;
          fill_cnt++;
          min_idx = lowest_slot(fill_cnt);
        end else if (v > top_vals[min_idx]) begin
          top_vals[min_idx] = v;
          min_idx = lowest_slot(k);
        end
        if (s_tlast) begin
          if (fill_cnt < k) begin
            want.kth_value = '0;
            want.too_few   = 1'b1;
          end else begin
            want.kth_value = top_vals[min_idx];
            want.too_few   = 1'b0;
          end
          pending_kth.insert(pending_kth.size(), want);
          fill_cnt = 0;
          min_idx  = 0;
        end
      end
    end
    open_results = pending_kth.size();
  end

endmodule

[sim/kth_largest_min_buffer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_largest_min_buffer_unit_tb
// stream test of the k-th largest selection unit
// ----------------------------------------------------------------------------
// Drives data sets through the input stream under many rank settings, with
// random gaps on both streams and one long hold-off of the result stream,
// while a checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module kth_largest_min_buffer_unit_tb;

  localparam int MAX_RANK     = 16;
  localparam int TOTAL_ITEMS  = 1920;     // directed plus random values
  localparam int SETTLE_WAIT  = 40;       // covers the longest item
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RUN_LIMIT_NS = 10_000_000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;     // [31:0] value
  logic        s_tlast;     // is_last
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;     // [31:0] kth_value
  logic        m_tuser;     // [0] too_few
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;    // [4:0] rank_k

  int fail_count;
  int open_results;
  int items_sent;
  bit steady;               // no idling on either stream while set
  bit hold_pending;         // asks the result side for one long hold-off

  kth_largest_min_buffer_unit #(.MAX_RANK(MAX_RANK)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  kth_largest_min_buffer_checker #(.MAX_RANK(MAX_RANK)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .open_results(open_results)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request,
  // counted here so the input side keeps offering meanwhile
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
      end
    end
  end

  // mix of wide random values, small values full of ties, and the extremes
  function automatic kthl_pkg::value_t draw_value();
    case ($urandom_range(3))
      0: return kthl_pkg::value_t'($urandom);
      1: return kthl_pkg::value_t'($urandom_range(16)) - 8;
      2: return kthl_pkg::value_t'($urandom_range(1000)) - 500;
      default: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // extreme and out-of-range ranks come up often
  function automatic kthl_pkg::rank_t draw_rank();
    case ($urandom_range(9))
      0:       return kthl_pkg::rank_t'(0);
      1:       return kthl_pkg::rank_t'(1);
      2:       return kthl_pkg::rank_t'(MAX_RANK);
      3:       return kthl_pkg::rank_t'(MAX_RANK + 1);
      4:       return kthl_pkg::rank_t'(31);
      default: return kthl_pkg::rank_t'($urandom_range(1, MAX_RANK));
    endcase
  endfunction

  // one value transfer; called and left at a falling edge, tvalid kept high
  task automatic send_value(kthl_pkg::value_t v, logic last);
    while (!steady && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // wait until every result is out and the unit has finished its last item
  task automatic settle();
    int spins;
    spins = 0;
    s_tvalid <= 1'b0;
    while (open_results != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_rank(kthl_pkg::rank_t r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int   set_count;
    int   set_len;
    logic close_set;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    items_sent   = 0;
    steady       = 1'b0;
    hold_pending = 1'b0;
    rst          = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset rank of 1: largest value, both extremes present
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(-1, 1'b1);
    // set of a single value
    send_value(32'sh8000_0000, 1'b1);

    // rank 0 behaves as 1; an equal value does not replace
    settle();
    write_rank(kthl_pkg::rank_t'(0));
    send_value(3, 1'b0);
    send_value(3, 1'b1);

    // rank beyond the buffer depth, set too short
    settle();
    write_rank(kthl_pkg::rank_t'(31));
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b1);

    // rank 3: ties on the minimum and replacements
    settle();
    write_rank(kthl_pkg::rank_t'(3));
    send_value(7, 1'b0);
    send_value(1, 1'b0);
    send_value(9, 1'b0);
    send_value(1, 1'b0);
    send_value(9, 1'b0);
    send_value(2, 1'b1);
    send_value(4, 1'b0);
    send_value(5, 1'b1);

    // rank lowered in the middle of a set: buffer counts as full
    settle();
    write_rank(kthl_pkg::rank_t'(4));
    send_value(10, 1'b0);
    send_value(20, 1'b0);
    send_value(30, 1'b0);
    settle();
    write_rank(kthl_pkg::rank_t'(2));
    send_value(25, 1'b1);

    // rank raised in the middle of a set: filling resumes
    send_value(1, 1'b0);
    send_value(2, 1'b0);
    settle();
    write_rank(kthl_pkg::rank_t'(5));
    send_value(3, 1'b0);
    send_value(4, 1'b0);
    send_value(5, 1'b1);

    // back-pressure: result side holds off while short sets keep coming,
    // so the pending result blocks the next final value and the input stalls
    settle();
    write_rank(kthl_pkg::rank_t'(2));
    hold_pending = 1'b1;
    repeat (12) begin
      set_len = $urandom_range(1, 3);
      for (int i = 0; i < set_len; i++) send_value(draw_value(), i == set_len - 1);
    end

    // random phases, each under its own rank; a phase sometimes ends
    // inside a set so the next rank takes over mid-set
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      write_rank(draw_rank());
      set_count = $urandom_range(2, 10);
      for (int s = 0; s < set_count; s++) begin
        case ($urandom_range(9))
          0:       set_len = 1;
          1:       set_len = $urandom_range(MAX_RANK + 1, 40);
          default: set_len = $urandom_range(1, 20);
        endcase
        close_set = !(s == set_count - 1 && $urandom_range(4) == 0);
        for (int i = 0; i < set_len; i++) begin
          steady = (items_sent >= 800 && items_sent < 1100);
          send_value(draw_value(), close_set && i == set_len - 1);
        end
      end
    end

    steady = 1'b0;
    settle();
    if (fail_count == 0 && open_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
